// ===== rtl/hhpc_pkg.sv =====
// Shared types and constants for the HTTP header packet classifier.
// Used by every module of the block; depends on nothing else.
package hhpc_pkg;

   localparam int COUNT_W = 32;
   localparam int POS_W = 16;
   localparam int CMP_W = (POS_W > 16) ? POS_W : 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W = 3;

   localparam logic [15:0] MAX_PARSE_RESET = 16'd1400;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
   localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
   localparam logic [7:0] TCP_OFFSET_BYTE = 8'd12;
   localparam logic [7:0] ETHERTYPE_HI = 8'h08;
   localparam logic [7:0] ETHERTYPE_LO = 8'h00;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
   localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
   localparam logic [POS_W-1:0] POS_IHL = POS_W'(14);
   localparam logic [POS_W-1:0] POS_PROTO = POS_W'(23);
   localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
   localparam logic [31:0] HTTP_WORD = 32'h48545450;
   localparam logic [31:0] CRLFCRLF_WORD = 32'h0D0A0D0A;

   localparam logic CSR_IDX_MAX_PARSE = 1'b0;

   typedef enum logic [2:0] {
      PH_HEADERS = 3'd0,
      PH_NOT_IP  = 3'd1,
      PH_NOT_L4  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_HTTP    = 3'd5,
      PH_NO_HTTP = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      TK_UNKNOWN = 2'd0,
      TK_TCP     = 2'd1,
      TK_UDP     = 2'd2
   } transport_type;

   typedef enum logic [2:0] {
      CLS_NOT_IP      = 3'd0,
      CLS_NOT_L4      = 3'd1,
      CLS_NO_HTTP     = 3'd2,
      CLS_NO_HDR_END  = 3'd3,
      CLS_NO_BODY     = 3'd4,
      CLS_COUNTED     = 3'd5
   } class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  frame_class;
      logic [31:0] match_count;
      logic        end_of_frame;
   } rsp_payload_type;

   // One finished frame verdict travelling through the queue.
   typedef struct packed {
      logic      valid;
      class_type frame_class;
   } verdict_type;

endpackage

// ===== rtl/hhpc_front.sv =====
// Front end: takes frame bytes, walks the Ethernet/IPv4/TCP/UDP headers and
// scans the payload, and pushes a class code on each frame's last byte. Uses hhpc_pkg.
module hhpc_front
   import hhpc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_payload,
   input  logic [15:0]     max_parse,
   output verdict_type     verdict
);

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [5:0]         ihb_ff, ihb_in;
   transport_type      tk_ff, tk_in;
   logic [POS_W-1:0]   pstart_ff, pstart_in;
   logic [31:0]        recent_ff, recent_in;
   logic               hdr_end_ff, hdr_end_in;
   logic               body_ff, body_in;

   phase_type          ex_phase;
   logic [POS_W-1:0]   ex_pos;
   logic [5:0]         ex_ihb;
   transport_type      ex_tk;
   logic [POS_W-1:0]   ex_pstart;
   logic [31:0]        ex_recent;
   logic               ex_hdr_end;
   logic               ex_body;
   class_type          cls;

   logic [7:0]         d;
   logic [POS_W-1:0]   p;
   logic [POS_W-1:0]   ip_end;
   logic [POS_W-1:0]   rel;
   logic [31:0]        shifted;

   assign d       = req_payload.data_byte;
   assign p       = pos_ff;
   assign ip_end  = POS_W'(ETH_HDR_BYTES) + POS_W'(ihb_ff);
   assign rel     = p - pstart_ff;
   assign shifted = {recent_ff[23:0], d};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADERS;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         ihb_ff     <= '0;
         tk_ff      <= TK_UNKNOWN;
         pstart_ff  <= '0;
         recent_ff  <= '0;
         hdr_end_ff <= 1'b0;
         body_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         ihb_ff     <= ihb_in;
         tk_ff      <= tk_in;
         pstart_ff  <= pstart_in;
         recent_ff  <= recent_in;
         hdr_end_ff <= hdr_end_in;
         body_ff    <= body_in;
      end
   end

   // Effect of the current byte on the parse state.
   always_comb begin
      ex_phase   = phase_ff;
      ex_pos     = pos_ff;
      ex_ihb     = ihb_ff;
      ex_tk      = tk_ff;
      ex_pstart  = pstart_ff;
      ex_recent  = recent_ff;
      ex_hdr_end = hdr_end_ff;
      ex_body    = body_ff;
      if (p != POS_MAX) begin
         ex_pos = p + POS_W'(1);
         case (phase_ff)
            PH_HEADERS: begin
               if ((p == POS_ETYPE_HI && d != ETHERTYPE_HI) ||
                   (p == POS_ETYPE_LO && d != ETHERTYPE_LO)) begin
                  ex_phase = PH_NOT_IP;
               end else if (p == POS_IHL) begin
                  if (d[3:0] < MIN_HDR_WORDS) begin
                     ex_phase = PH_NOT_IP;
                  end else begin
                     ex_ihb = {d[3:0], 2'b00};
                  end
               end else if (p == POS_PROTO) begin
                  if (d == PROTO_TCP) begin
                     ex_tk = TK_TCP;
                  end else if (d == PROTO_UDP) begin
                     ex_tk     = TK_UDP;
                     ex_pstart = ip_end + POS_W'(UDP_HDR_BYTES);
                     ex_phase  = PH_PAYLOAD;
                  end else begin
                     ex_phase = PH_NOT_L4;
                  end
               end else if (tk_ff == TK_TCP && p == ip_end + POS_W'(TCP_OFFSET_BYTE)) begin
                  if (d[7:4] < MIN_HDR_WORDS) begin
                     ex_phase = PH_NOT_L4;
                  end else begin
                     ex_pstart = ip_end + POS_W'({d[7:4], 2'b00});
                     ex_phase  = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (p >= pstart_ff) begin
                  ex_recent = shifted;
                  if (rel == POS_W'(3)) begin
                     ex_phase = (shifted == HTTP_WORD) ? PH_HTTP : PH_NO_HTTP;
                  end
               end
            end
            PH_HTTP: begin
               if (CMP_W'(rel) < CMP_W'(max_parse)) begin
                  ex_recent = shifted;
                  if (hdr_end_ff) begin
                     ex_body = 1'b1;
                  end else if (shifted == CRLFCRLF_WORD) begin
                     ex_hdr_end = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Verdict from the state after this byte.
   always_comb begin
      case (ex_phase)
         PH_HEADERS: cls = (ex_pos <= POS_IHL) ? CLS_NOT_IP : CLS_NOT_L4;
         PH_NOT_IP:  cls = CLS_NOT_IP;
         PH_NOT_L4:  cls = CLS_NOT_L4;
         PH_HTTP:    cls = !ex_hdr_end ? CLS_NO_HDR_END :
                           (ex_body ? CLS_COUNTED : CLS_NO_BODY);
         default:    cls = CLS_NO_HTTP;
      endcase
   end

   // A frame's last byte returns the parser to its reset state.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      ihb_in     = ihb_ff;
      tk_in      = tk_ff;
      pstart_in  = pstart_ff;
      recent_in  = recent_ff;
      hdr_end_in = hdr_end_ff;
      body_in    = body_ff;
      if (accept) begin
         if (req_payload.last_byte) begin
            phase_in   = PH_HEADERS;
            pos_in     = '0;
            ihb_in     = '0;
            tk_in      = TK_UNKNOWN;
            pstart_in  = '0;
            recent_in  = '0;
            hdr_end_in = 1'b0;
            body_in    = 1'b0;
         end else begin
            phase_in   = ex_phase;
            pos_in     = ex_pos;
            ihb_in     = ex_ihb;
            tk_in      = ex_tk;
            pstart_in  = ex_pstart;
            recent_in  = ex_recent;
            hdr_end_in = ex_hdr_end;
            body_in    = ex_body;
         end
      end
   end

   assign verdict.valid       = accept & req_payload.last_byte;
   assign verdict.frame_class = cls;

endmodule

// ===== rtl/hhpc_queue.sv =====
// Short verdict queue between the parser and the counting back end.
// Uses hhpc_pkg.
module hhpc_queue
   import hhpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  verdict_type push,
   input  logic        pop,
   output logic        full,
   output verdict_type head
);

   class_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;
   logic                  do_pop;

   assign do_pop    = pop & (fill_ff != '0);
   assign wr_ptr_in = push.valid ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (push.valid && !do_pop) begin
         fill_in = fill_ff + (QUEUE_AW+1)'(1);
      end else if (!push.valid && do_pop) begin
         fill_in = fill_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.frame_class;
      end
   end

   assign full             = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head.valid       = (fill_ff != '0);
   assign head.frame_class = entry_ff[rd_ptr_ff];

   // The front end is held off before the queue can overflow.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("verdict pushed into a full queue");

   // Fill level moves by one only when exactly one side acts.
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !do_pop) |=> fill_ff == $past(fill_ff) + (QUEUE_AW+1)'(1))
      else $error("queue fill level lost a push");

endmodule

// ===== rtl/hhpc_back.sv =====
// Back end: takes verdicts from the queue, keeps the saturating match count
// and holds the result register towards the receiver. Uses hhpc_pkg.
module hhpc_back
   import hhpc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  verdict_type     head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   rsp_payload_type    payload_ff, payload_in;
   logic [63:0]        count_wide;

   assign pop = head.valid & (!valid_ff | !rsp_stall);

   always_comb begin
      count_in = count_ff;
      if (pop && head.frame_class == CLS_COUNTED && count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   assign count_wide = 64'(count_in);

   always_comb begin
      valid_in   = valid_ff & rsp_stall;
      payload_in = payload_ff;
      if (pop) begin
         valid_in                = 1'b1;
         payload_in.frame_class  = head.frame_class;
         payload_in.match_count  = count_wide[31:0];
         payload_in.end_of_frame = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   // A counted frame below saturation advances the count by exactly one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (pop && head.frame_class == CLS_COUNTED && count_ff != COUNT_MAX)
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("match count did not advance on a counted frame");

   // Without a verdict taken the count stays put.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(count_ff))
      else $error("match count changed without a verdict");

endmodule

// ===== rtl/http_header_packet_classifier_top.sv =====
// Top level of the HTTP header packet classifier: byte channel in, verdict
// channel out, APB-style register port. Uses hhpc_pkg, hhpc_front, hhpc_queue, hhpc_back.
//
// Usage. Frame bytes arrive on the req_ channel one request per cycle when not stalled,
// starting at the Ethernet header, with last_byte set on the final captured byte. Each
// frame yields exactly one result request on the rsp_ channel, issued for its last byte:
// the class code, the running count of HTTP frames with a body, and end_of_frame.
// Throughput is one byte per cycle while req_stall is low. The verdict is written into
// the queue when a last byte is accepted and is moved into the result register when
// the back end pops it; rsp_valid rises when the result register is loaded.
// A four-entry queue separates the parser from the counting back end. When the
// receiver stalls, verdicts pile up there; req_stall rises only once the queue
// is full, so short stalls do not hold up the byte stream.
// Reset (synchronous, active high) clears the parser, the queue, the count and
// the result valid flag, and sets max_parse to 1400. max_parse sits at byte
// address 0 and should be written only while no frame is in flight.
module http_header_packet_classifier_top
   import hhpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [15:0]  max_parse_ff, max_parse_in;
   logic         req_accept;
   logic         queue_full;
   logic         queue_pop;
   logic         csr_write;
   verdict_type  front_verdict;
   verdict_type  queue_head;

   // Register port: always ready, word index taken from address bit 2.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      max_parse_in = max_parse_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_MAX_PARSE) begin
         max_parse_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_parse_ff <= MAX_PARSE_RESET;
      end else begin
         max_parse_ff <= max_parse_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_PARSE) ? {16'd0, max_parse_ff} : 32'd0;

   // Bytes are held off only while the verdict queue has no room.
   assign req_stall  = queue_full;
   assign req_accept = req_valid & !req_stall;

   hhpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_payload (req_payload),
      .max_parse   (max_parse_ff),
      .verdict     (front_verdict)
   );

   hhpc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_verdict),
      .pop   (queue_pop),
      .full  (queue_full),
      .head  (queue_head)
   );

   hhpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (queue_head),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
